>>> rtl/core/bpc_pkg.sv
package bpc_pkg;

  localparam int unsigned GAIN_FRAC = 6;
  localparam int unsigned OUT_FRAC  = 4;
  localparam int unsigned HOLD_DEFAULT_MS = 40;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TIDX_W     = 8;
  localparam int unsigned TVAL_W     = 15;
  localparam int unsigned PRESS_W    = 19;
  localparam int unsigned OGAIN_W    = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEVEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN = 2'd2;

  localparam logic [CFG_DATA_W-1:0] BASE_LEVEL_RST  = 16'd0;
  localparam logic [CFG_DATA_W-1:0] BASE_GAIN_RST   = 16'd128;
  localparam logic [OGAIN_W-1:0]    OUTPUT_GAIN_RST = 8'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SMOOTH,
    ST_SCALE,
    ST_READ,
    ST_INTERP,
    ST_GAIN
  } bpc_state_e;

  typedef struct packed {
    logic capture;
    logic smooth;
    logic scale;
    logic read;
    logic interp;
    logic load_out;
  } bpc_cmd_t;

  typedef struct packed {
    logic is_write;
  } bpc_status_t;

endpackage

>>> rtl/core/bpc_ctrl.sv
module bpc_ctrl
  import bpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  bpc_status_t status_i,
  output bpc_cmd_t    cmd_o
);

  bpc_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.capture = accept;
    case (state_q)
      ST_IDLE: begin
        if (accept && !status_i.is_write) begin
          state_d = ST_SMOOTH;
        end
      end
      ST_SMOOTH: begin
        cmd_o.smooth = 1'b1;
        state_d      = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_READ;
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_INTERP;
      end
      ST_INTERP: begin
        cmd_o.interp = 1'b1;
        state_d      = ST_GAIN;
      end
      ST_GAIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.smooth, cmd_o.scale, cmd_o.read, cmd_o.interp, cmd_o.load_out}))
    else $error("more than one datapath step issued in a cycle");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("waiting result overwritten");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_o)
    else $error("loaded result not presented");

  a_sample_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !status_i.is_write) |=> (state_q == ST_SMOOTH))
    else $error("accepted sample did not start processing");

endmodule

>>> rtl/core/bpc_dpath.sv
module bpc_dpath
  import bpc_pkg::*;
#(
  parameter int unsigned ADC_BITS    = 16,
  parameter int unsigned MAP_BITS    = 7,
  parameter int unsigned SMOOTH_BITS = 4,
  parameter int unsigned HOLD_MS     = 40
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bpc_cmd_t              cmd_i,
  output bpc_status_t           status_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  kind_i,
  input  logic [SAMPLE_W-1:0]   sample_i,
  input  logic [TIME_W-1:0]     now_ms_i,
  input  logic [TIDX_W-1:0]     table_index_i,
  input  logic [TVAL_W-1:0]     table_value_i,
  output logic [PRESS_W-1:0]    pressure_o,
  output logic                  muted_o
);

  localparam int unsigned ACC_W = ADC_BITS + SMOOTH_BITS;
  localparam int unsigned FB    = ADC_BITS - MAP_BITS;
  localparam int unsigned WW    = FB + 1;
  localparam int unsigned DEPTH = (1 << MAP_BITS) + 1;
  localparam int unsigned AW    = MAP_BITS + 1;
  localparam int unsigned IW    = TVAL_W + WW + 1;
  localparam int unsigned GW    = IW + OGAIN_W;
  localparam logic [ADC_BITS-1:0] ADC_FULL  = '1;
  localparam logic [ADC_BITS-1:0] FRAC_MASK = ADC_BITS'((32'd1 << FB) - 32'd1);
  localparam logic [WW-1:0]       RES       = WW'(32'd1 << FB);

  logic [CFG_DATA_W-1:0] base_level_q, base_gain_q;
  logic [OGAIN_W-1:0]    output_gain_q;

  logic [ADC_BITS-1:0] samp_q;
  logic [TIME_W-1:0]   now_q;
  logic [ACC_W-1:0]    acc_q;
  logic [ADC_BITS-1:0] v_q;
  logic                hold_q;
  logic [TIME_W-1:0]   deadline_q;
  logic [31:0]         prod_q;
  logic                mute_q;
  logic                zero_q;
  logic [WW-1:0]       frac_q;
  logic [TVAL_W-1:0]   rd0_q, rd1_q;
  logic [IW-1:0]       interp_q;
  logic [PRESS_W-1:0]  pressure_q;
  logic                muted_q;

  logic [TVAL_W-1:0] mem [DEPTH];

  logic [ACC_W:0]       acc_sum;
  logic [ACC_W-1:0]     acc_new;
  logic [CFG_DATA_W:0]  vx;
  logic                 above;
  logic [CFG_DATA_W-1:0] diff;
  logic [31:0]          prod;
  logic [TIME_W-1:0]    left;
  logic                 hold_keep, hold_start;
  logic [ADC_BITS-1:0]  reading;
  logic [MAP_BITS-1:0]  idx;
  logic [AW-1:0]        addr0, addr1;
  logic [IW-1:0]        interp_d;
  logic [GW-1:0]        gained;

  assign status_o.is_write = kind_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_level_q  <= BASE_LEVEL_RST;
      base_gain_q   <= BASE_GAIN_RST;
      output_gain_q <= OUTPUT_GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BASE_LEVEL:  base_level_q  <= cfg_wdata_i;
        CFG_BASE_GAIN:   base_gain_q   <= cfg_wdata_i;
        CFG_OUTPUT_GAIN: output_gain_q <= cfg_wdata_i[OGAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture && kind_i && (32'(table_index_i) < DEPTH)) begin
      mem[AW'(table_index_i)] <= table_value_i;
    end
    if (cmd_i.read) begin
      rd0_q <= mem[addr0];
      rd1_q <= mem[addr1];
    end
  end

  assign acc_sum = {1'b0, acc_q} + (ACC_W + 1)'(samp_q) - (ACC_W + 1)'(acc_q >> SMOOTH_BITS);
  assign acc_new = acc_sum[ACC_W-1:0];

  assign vx    = (CFG_DATA_W + 1)'(v_q);
  assign above = vx > {1'b0, base_level_q};
  assign diff  = CFG_DATA_W'(vx - {1'b0, base_level_q});
  assign prod  = diff * base_gain_q;

  assign left       = deadline_q - now_q;
  assign hold_keep  = hold_q && (left != '0) && !left[TIME_W-1] && (vx < {base_level_q, 1'b0});
  assign hold_start = !hold_keep && (vx < (CFG_DATA_W + 1)'(base_level_q >> 1));

  assign reading = ((prod_q >> GAIN_FRAC) > 32'(ADC_FULL)) ? ADC_FULL
                 : ADC_BITS'(prod_q >> GAIN_FRAC);
  assign idx   = MAP_BITS'(reading >> FB);
  assign addr0 = AW'(idx);
  assign addr1 = AW'(idx) + AW'(1);

  assign interp_d = IW'(rd0_q) * IW'(RES - frac_q) + IW'(rd1_q) * IW'(frac_q);
  assign gained   = GW'(interp_q) * GW'(output_gain_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      hold_q     <= 1'b0;
      deadline_q <= '0;
    end else begin
      if (cmd_i.smooth) begin
        acc_q <= acc_new;
      end
      if (cmd_i.scale) begin
        if (hold_start) begin
          hold_q     <= 1'b1;
          deadline_q <= now_q + TIME_W'(HOLD_MS);
        end else if (!hold_keep) begin
          hold_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture && !kind_i) begin
      samp_q <= sample_i[ADC_BITS-1:0];
      now_q  <= now_ms_i;
    end
    if (cmd_i.smooth) begin
      v_q <= ADC_BITS'(acc_new >> SMOOTH_BITS);
    end
    if (cmd_i.scale) begin
      prod_q <= above ? prod : '0;
      mute_q <= hold_keep || hold_start;
    end
    if (cmd_i.read) begin
      zero_q <= (reading == '0);
      frac_q <= WW'(reading & FRAC_MASK);
    end
    if (cmd_i.interp) begin
      interp_q <= interp_d;
    end
    if (cmd_i.load_out) begin
      muted_q    <= mute_q;
      pressure_q <= (mute_q || zero_q) ? '0 : PRESS_W'(gained >> (OUT_FRAC + FB));
    end
  end

  assign pressure_o = pressure_q;
  assign muted_o    = muted_q;

endmodule

>>> rtl/core/breath_pressure_conditioner.sv
// Breath pressure conditioner. Items enter on a valid/ready channel: kind 0
// is a sensor sample with a millisecond timestamp, kind 1 writes one word of
// the curve table (if its index is in range) and produces no result. Each
// sample produces exactly one result item (pressure, muted) on a valid/ready
// output channel. A table write is done when the item is accepted, and
// the block stays ready. A sample passes a controller that steps a shared
// datapath through smoothing, baseline gain, table read, interpolation and
// output gain, one step per cycle while the output register is free; a new
// item is taken only once the sample's last step is done. The two-port
// table read sets one of those steps.
// The output register holds a finished result while the receiver stalls;
// the next sample is accepted meanwhile and waits in its last step until
// the register is free. Configuration registers have a plain write port;
// the user must write them only while the block is idle; it does not enforce this.
// Reset clears the smoothing accumulator, the hold state and the
// configuration registers to their defaults; the curve table is not cleared
// and must be loaded before samples that read it.
module breath_pressure_conditioner
  import bpc_pkg::*;
#(
  parameter int unsigned ADC_BITS    = 16,
  parameter int unsigned MAP_BITS    = 7,
  parameter int unsigned SMOOTH_BITS = 4,
  parameter int unsigned HOLD_MS     = 40
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  kind_i,
  input  logic [SAMPLE_W-1:0]   sample_i,
  input  logic [TIME_W-1:0]     now_ms_i,
  input  logic [TIDX_W-1:0]     table_index_i,
  input  logic [TVAL_W-1:0]     table_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PRESS_W-1:0]    pressure_o,
  output logic                  muted_o
);

  bpc_cmd_t    cmd;
  bpc_status_t status;

  bpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bpc_dpath #(
    .ADC_BITS    (ADC_BITS),
    .MAP_BITS    (MAP_BITS),
    .SMOOTH_BITS (SMOOTH_BITS),
    .HOLD_MS     (HOLD_MS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .kind_i        (kind_i),
    .sample_i      (sample_i),
    .now_ms_i      (now_ms_i),
    .table_index_i (table_index_i),
    .table_value_i (table_value_i),
    .pressure_o    (pressure_o),
    .muted_o       (muted_o)
  );

endmodule

>>> verif/bpc_tb_pkg.sv
package bpc_tb_pkg;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_WRITE  = 1'b1;

  localparam logic [bpc_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [bpc_pkg::PRESS_W-1:0] pressure;
    logic                        muted;
  } press_result_t;

endpackage

>>> verif/bpc_checker.sv
module bpc_checker
  import bpc_pkg::*;
  import bpc_tb_pkg::*;
#(
  parameter int unsigned ADC_BITS    = 16,
  parameter int unsigned MAP_BITS    = 7,
  parameter int unsigned SMOOTH_BITS = 4,
  parameter int unsigned HOLD_MS     = 40
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic                  kind_i,
  input  logic [SAMPLE_W-1:0]   sample_i,
  input  logic [TIME_W-1:0]     now_ms_i,
  input  logic [TIDX_W-1:0]     table_index_i,
  input  logic [TVAL_W-1:0]     table_value_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [PRESS_W-1:0]    pressure_i,
  input  logic                  muted_i,
  output int unsigned           mismatches_o,
  output int unsigned           outstanding_o,
  output int unsigned           samples_o,
  output int unsigned           muted_count_o,
  output int unsigned           writes_o
);

  localparam int unsigned TBL_DEPTH = (1 << MAP_BITS) + 1;
  localparam int unsigned SEG_BITS  = ADC_BITS - MAP_BITS;
  localparam logic [31:0] ADC_MAX   = 32'((1 << ADC_BITS) - 1);
  localparam logic [31:0] SEG_SPAN  = 32'(1 << SEG_BITS);

  logic [31:0]       smooth_acc_q;
  logic              hold_on_q;
  logic [31:0]       hold_end_q;
  logic [TVAL_W-1:0] curve_q [TBL_DEPTH];
  logic [15:0]       level_q;
  logic [15:0]       gain_q;
  logic [7:0]        out_gain_q;

  press_result_t     pending_results[$];
  press_result_t     oldest;

  function automatic press_result_t condition_sample(logic [SAMPLE_W-1:0] raw,
                                                     logic [TIME_W-1:0] now);
    logic [31:0]   v;
    logic [31:0]   reading;
    logic [31:0]   left;
    logic [31:0]   frac;
    logic [31:0]   idx;
    logic [63:0]   scaled;
    logic [63:0]   mix;
    press_result_t r;
    r = '0;
    smooth_acc_q = smooth_acc_q + (32'(raw) & ADC_MAX) - (smooth_acc_q >> SMOOTH_BITS);
    v = smooth_acc_q >> SMOOTH_BITS;
    reading = '0;
    if (v > 32'(level_q)) begin
      scaled = (64'(v - 32'(level_q)) * 64'(gain_q)) >> GAIN_FRAC;
      reading = (scaled > 64'(ADC_MAX)) ? ADC_MAX : scaled[31:0];
    end
    if (hold_on_q) begin
      left = hold_end_q - now;
      if (left != 0 && left < 32'h8000_0000 && v < (32'(level_q) << 1)) begin
        r.muted = 1'b1;
        return r;
      end
      hold_on_q = 1'b0;
    end
    if (v < 32'(level_q >> 1)) begin
      hold_on_q  = 1'b1;
      hold_end_q = now + 32'(HOLD_MS);
      r.muted    = 1'b1;
      return r;
    end
    if (reading == 0) return r;
    frac = reading & (SEG_SPAN - 1);
    idx  = reading >> SEG_BITS;
    if (idx + 1 >= TBL_DEPTH) idx = TBL_DEPTH - 2;
    mix = 64'(curve_q[idx]) * 64'(SEG_SPAN - frac) + 64'(curve_q[idx + 1]) * 64'(frac);
    mix = (mix * 64'(out_gain_q)) >> (OUT_FRAC + SEG_BITS);
    r.pressure = mix[PRESS_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_acc_q  = '0;
      hold_on_q     = 1'b0;
      hold_end_q    = '0;
      level_q       = BASE_LEVEL_RST;
      gain_q        = BASE_GAIN_RST;
      out_gain_q    = OUTPUT_GAIN_RST;
      pending_results.delete();
      mismatches_o  = 0;
      outstanding_o = 0;
      samples_o     = 0;
      muted_count_o = 0;
      writes_o      = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BASE_LEVEL:  level_q    = cfg_wdata_i;
          CFG_BASE_GAIN:   gain_q     = cfg_wdata_i;
          CFG_OUTPUT_GAIN: out_gain_q = cfg_wdata_i[OGAIN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result item with no expectation: pressure %0d, muted %0d",
                 pressure_i, muted_i);
          mismatches_o++;
        end else begin
          oldest = pending_results.pop_front();
          if (oldest.pressure !== pressure_i) begin
            $error("pressure mismatch: expected %0d, actual %0d", oldest.pressure, pressure_i);
            mismatches_o++;
          end
          if (oldest.muted !== muted_i) begin
            $error("muted mismatch: expected %0d, actual %0d", oldest.muted, muted_i);
            mismatches_o++;
          end
          if (oldest.muted) muted_count_o++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (kind_i == KIND_WRITE) begin
          if (32'(table_index_i) < TBL_DEPTH) curve_q[table_index_i] = table_value_i;
          writes_o++;
        end else begin
          pending_results.push_back(condition_sample(sample_i, now_ms_i));
          samples_o++;
        end
      end
      outstanding_o = pending_results.size();
    end
  end

endmodule

>>> verif/tb.sv
module tb;
  import bpc_pkg::*;
  import bpc_tb_pkg::*;

  localparam int unsigned ADC_BITS        = 16;
  localparam int unsigned MAP_BITS        = 7;
  localparam int unsigned SMOOTH_BITS     = 4;
  localparam int unsigned HOLD_MS         = 40;
  localparam int unsigned TABLE_LAST      = 1 << MAP_BITS;
  localparam int unsigned ITEM_GOAL       = 650;
  localparam int unsigned SETTLE_CYCLES   = 12;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned DRAIN_LIMIT     = 20000;

  typedef enum logic [1:0] {
    BR_REST,
    BR_BLOW,
    BR_TONGUE
  } breath_e;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  item_kind = KIND_SAMPLE;
  logic [SAMPLE_W-1:0]   item_sample = '0;
  logic [TIME_W-1:0]     item_now = '0;
  logic [TIDX_W-1:0]     item_tidx = '0;
  logic [TVAL_W-1:0]     item_tval = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PRESS_W-1:0]    pressure;
  logic                  muted;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned samples_seen;
  int unsigned muted_seen;
  int unsigned writes_seen;

  logic [15:0] level_cfg = BASE_LEVEL_RST;
  logic [31:0] clock_ms = '0;
  breath_e     stage = BR_REST;
  int unsigned stage_left = 0;
  int unsigned items_done = 0;
  int unsigned settings_done = 0;
  logic        sender_steady = 1'b0;
  logic        recv_steady = 1'b0;
  logic        hold_off_req = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  breath_pressure_conditioner #(
    .ADC_BITS   (ADC_BITS),
    .MAP_BITS   (MAP_BITS),
    .SMOOTH_BITS(SMOOTH_BITS),
    .HOLD_MS    (HOLD_MS)
  ) DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .kind_i       (item_kind),
    .sample_i     (item_sample),
    .now_ms_i     (item_now),
    .table_index_i(item_tidx),
    .table_value_i(item_tval),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .pressure_o   (pressure),
    .muted_o      (muted)
  );

  bpc_checker #(
    .ADC_BITS   (ADC_BITS),
    .MAP_BITS   (MAP_BITS),
    .SMOOTH_BITS(SMOOTH_BITS),
    .HOLD_MS    (HOLD_MS)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .kind_i       (item_kind),
    .sample_i     (item_sample),
    .now_ms_i     (item_now),
    .table_index_i(item_tidx),
    .table_value_i(item_tval),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .pressure_i   (pressure),
    .muted_i      (muted),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding),
    .samples_o    (samples_seen),
    .muted_count_o(muted_seen),
    .writes_o     (writes_seen)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [15:0] breath_sample();
    int lvl;
    int lo;
    int hi;
    lvl = int'(level_cfg);
    if (stage_left == 0) begin
      stage = breath_e'($urandom_range(2, 0));
      stage_left = (stage == BR_TONGUE) ? $urandom_range(30, 8) : $urandom_range(25, 3);
    end
    stage_left--;
    case (stage)
      BR_REST: begin
        lo = lvl - 600;
        hi = lvl + 600;
      end
      BR_BLOW: begin
        lo = lvl;
        hi = 65535;
      end
      default: begin
        lo = 0;
        hi = lvl / 4;
      end
    endcase
    if (lo < 0) lo = 0;
    if (hi > 65535) hi = 65535;
    return 16'($urandom_range(hi, lo));
  endfunction

  task automatic offer_item(logic kind_v, logic [15:0] smp, logic [31:0] t,
                            logic [7:0] ti, logic [14:0] tv);
    int unsigned gap;
    gap = sender_steady ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_kind   = kind_v;
    item_sample = smp;
    item_now    = t;
    item_tidx   = ti;
    item_tval   = tv;
    in_valid    = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (kind_v == KIND_SAMPLE || ti <= TABLE_LAST) items_done++;
  endtask

  task automatic offer_sample(logic [15:0] smp, int unsigned step_ms);
    clock_ms = clock_ms + step_ms;
    offer_item(KIND_SAMPLE, smp, clock_ms, 8'($urandom), 15'($urandom));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_BASE_LEVEL) level_cfg = data;
  endtask

  task automatic settle();
    int unsigned waited;
    waited = 0;
    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_setting(logic [15:0] lvl, logic [15:0] gain, logic [7:0] og);
    settle();
    write_reg(CFG_BASE_LEVEL, lvl);
    write_reg(CFG_BASE_GAIN, gain);
    write_reg(CFG_OUTPUT_GAIN, {8'($urandom), og});
    write_reg(CFG_SPARE, 16'($urandom));
    settings_done++;
  endtask

  task automatic run_stretch(int unsigned n);
    int unsigned r;
    int unsigned ti;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(99, 0);
      if (r < 5) begin
        ti = ($urandom_range(3, 0) == 0) ? $urandom_range(255, TABLE_LAST + 1)
                                         : $urandom_range(TABLE_LAST, 0);
        offer_item(KIND_WRITE, 16'($urandom), 32'($urandom), 8'(ti), 15'($urandom));
      end else if (r < 10) begin
        clock_ms = $urandom;
        offer_sample(16'($urandom), 0);
      end else begin
        offer_sample(breath_sample(), $urandom_range(6, 0));
      end
    end
  endtask

  initial begin : receiver
    int unsigned stall_left;
    logic        hold_off_used;
    stall_left    = 0;
    hold_off_used = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_off_used) begin
        out_ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_used = 1'b1;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if ($urandom_range(99, 0) < 2) recv_steady = !recv_steady;
        if (!recv_steady) stall_left = pick_gap();
      end
    end
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    for (int unsigned i = 0; i <= TABLE_LAST; i++) begin
      offer_item(KIND_WRITE, 16'($urandom), 32'($urandom), 8'(i), 15'($urandom));
    end

    offer_item(KIND_WRITE, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 15'h7FFF);
    offer_item(KIND_WRITE, 16'h0000, 32'h0000_0000, 8'(TABLE_LAST + 1), 15'h0000);
    clock_ms = '0;
    offer_sample(16'h0000, 0);
    offer_sample(16'hFFFF, 1);
    offer_sample(16'hFFFF, 1);

    apply_setting(16'd12000, 16'hFFFF, 8'hFF);
    clock_ms = 32'hFFFF_FFF0;
    repeat (5) offer_sample(16'h0000, 2);
    repeat (4) offer_sample(16'h0000, 12);
    repeat (8) offer_sample(16'hFFFF, 10);

    apply_setting(16'hFFFF, 16'hFFFF, 8'hFF);
    run_stretch(70);

    apply_setting(16'h0000, 16'h0000, 8'h00);
    hold_off_req  = 1'b1;
    sender_steady = 1'b1;
    run_stretch(30);
    sender_steady = 1'b0;
    run_stretch(40);

    apply_setting(16'($urandom_range(20000, 1000)), 16'hFFFF, 8'hFF);
    run_stretch(80);

    apply_setting(16'h0000, 16'($urandom), 8'($urandom));
    run_stretch(80);

    while (items_done < ITEM_GOAL) begin
      case ($urandom_range(2, 0))
        0: apply_setting(16'($urandom_range(25000, 2000)), 16'($urandom_range(512, 32)),
                         8'($urandom_range(64, 1)));
        1: apply_setting(16'($urandom_range(8000, 500)), 16'($urandom_range(256, 64)),
                         8'($urandom_range(255, 16)));
        default: apply_setting(16'($urandom), 16'($urandom), 8'($urandom));
      endcase
      clock_ms = ($urandom_range(1, 0) == 0) ? 32'hFFFF_FF00 + $urandom_range(255, 0)
                                             : $urandom;
      sender_steady = ($urandom_range(3, 0) == 0);
      run_stretch($urandom_range(100, 60));
      sender_steady = 1'b0;
    end

    settle();
    if (outstanding != 0) $error("%0d expected results never arrived", outstanding);
    $display("Covered %0d samples (%0d muted) and %0d table writes over %0d register settings,",
             samples_seen, muted_seen, writes_seen, settings_done);
    $display("including wrapped timestamps, hold expiry and a long output stall.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
